// ----- rtl/fcr_pkg.sv -----
// Shared types and constants for the framed command receiver.
// No dependencies; used by fcr_frame and framed_command_receiver.
`default_nettype none

package fcr_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned FieldW    = 15;
  localparam int unsigned FieldSh   = 7;
  // Payload positions that feed a message; later bytes are never read.
  localparam int unsigned MsgBytes  = 8;
  localparam int unsigned PosW      = $clog2(MsgBytes + 1);
  localparam int unsigned SlotW     = $clog2(MsgBytes);
  localparam int unsigned CfgIdxW   = 1;

  localparam logic [CfgIdxW-1:0] CFG_START_CODE = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_STOP_CODE  = 1'd1;

  localparam logic [ByteW-1:0] START_RST = 8'd2;
  localparam logic [ByteW-1:0] STOP_RST  = 8'd3;

  typedef struct packed {
    logic [ByteW-1:0]  msg_type;
    logic [ByteW-1:0]  msg_id;
    logic [FieldW-1:0] msg_distance;
    logic [FieldW-1:0] msg_speed;
    logic [FieldW-1:0] msg_angle;
  } msg_t;

  // (hi << 7) | lo in a 15-bit field; hi fills bits 14..7 exactly.
  function automatic logic [FieldW-1:0] join_pair(input logic [ByteW-1:0] hi,
                                                  input logic [ByteW-1:0] lo);
    logic [FieldW-1:0] hi_w;
    logic [FieldW-1:0] lo_w;
    hi_w = {hi, {FieldSh{1'b0}}};
    lo_w = {{(FieldW-ByteW){1'b0}}, lo};
    return hi_w | lo_w;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/framed_command_receiver.sv -----
// Framed command receiver top level: input stage, frame state, message register.
// Depends on fcr_pkg and fcr_frame.
//
// Usage:
//   Input channel (in_valid/in_ready/in_rx_byte) takes one serial byte per
//   request. While idle, bytes are dropped until start_code arrives. In a
//   frame, bytes other than stop_code fill payload positions 0..7 in order;
//   extra bytes are dropped. stop_code closes the frame and one message
//   request is issued on the output channel (out_valid/out_ready/out_msg_*).
//   Config port: cfg_we writes cfg_wdata to register cfg_index
//   (0 = start_code, 1 = stop_code); write only while no byte is in flight.
//   Timing: a byte is registered in the input stage on accept and processed
//   when it leaves that stage; a closing stop byte then loads the message
//   register, which raises out_valid.
//   Throughput: one byte per cycle unless stalled, set by the single input stage.
//   Stall: while a message waits in the output register, non-closing bytes
//   still flow; a second stop byte waits in the input stage, and in_ready
//   drops, until the message is taken.
//   Reset: idle, payload zero, start_code = 2, stop_code = 3.
`default_nettype none

module framed_command_receiver (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [fcr_pkg::CfgIdxW-1:0]         cfg_index,
  input  wire logic [fcr_pkg::ByteW-1:0]           cfg_wdata,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [fcr_pkg::ByteW-1:0]           in_rx_byte,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [fcr_pkg::ByteW-1:0]                out_msg_type,
  output logic [fcr_pkg::ByteW-1:0]                out_msg_id,
  output logic [fcr_pkg::FieldW-1:0]               out_msg_distance,
  output logic [fcr_pkg::FieldW-1:0]               out_msg_speed,
  output logic [fcr_pkg::FieldW-1:0]               out_msg_angle
);

  logic [fcr_pkg::ByteW-1:0] start_code_r;
  logic [fcr_pkg::ByteW-1:0] stop_code_r;
  logic                      stg_vld_r;
  logic [fcr_pkg::ByteW-1:0] stg_byte_r;
  logic                      out_vld_r;
  fcr_pkg::msg_t             out_msg_r;
  logic                      emit;
  logic                      stg_go;
  fcr_pkg::msg_t             msg;

  // Config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_code_r <= fcr_pkg::START_RST;
      stop_code_r  <= fcr_pkg::STOP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fcr_pkg::CFG_START_CODE: start_code_r <= cfg_wdata;
        fcr_pkg::CFG_STOP_CODE:  stop_code_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input stage advances unless a message must wait for the output slot
  assign stg_go   = stg_vld_r && (!emit || !out_vld_r || out_ready);
  assign in_ready = !stg_vld_r || stg_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else if (in_ready) begin
      stg_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_byte_r <= in_rx_byte;
    end
  end

  fcr_frame u_frame (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (stg_go),
    .rx_byte    (stg_byte_r),
    .start_code (start_code_r),
    .stop_code  (stop_code_r),
    .emit       (emit),
    .msg        (msg)
  );

  // Message register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (stg_go && emit) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_go && emit) begin
      out_msg_r <= msg;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_msg_type     = out_msg_r.msg_type;
  assign out_msg_id       = out_msg_r.msg_id;
  assign out_msg_distance = out_msg_r.msg_distance;
  assign out_msg_speed    = out_msg_r.msg_speed;
  assign out_msg_angle    = out_msg_r.msg_angle;

endmodule

`default_nettype wire

// ----- rtl/fcr_frame.sv -----
// Frame state: idle/in-frame flag, write position and payload bytes.
// Depends on fcr_pkg. Updates once per processed byte (step).
`default_nettype none

module fcr_frame (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      step,
  input  wire logic [fcr_pkg::ByteW-1:0] rx_byte,
  input  wire logic [fcr_pkg::ByteW-1:0] start_code,
  input  wire logic [fcr_pkg::ByteW-1:0] stop_code,
  output logic                           emit,
  output fcr_pkg::msg_t                  msg
);

  logic                           in_frame_r, in_frame_nxt;
  logic [fcr_pkg::PosW-1:0]       pos_r, pos_nxt;
  logic [fcr_pkg::ByteW-1:0]      pl_r [fcr_pkg::MsgBytes];
  logic                           wr_en;

  // Frame closes on stop code while in a frame
  assign emit  = in_frame_r && (rx_byte == stop_code);
  assign wr_en = in_frame_r && !emit && (pos_r < fcr_pkg::PosW'(fcr_pkg::MsgBytes));

  // Message view of the current payload
  always_comb begin
    msg.msg_type     = pl_r[0];
    msg.msg_id       = pl_r[1];
    msg.msg_distance = fcr_pkg::join_pair(pl_r[2], pl_r[3]);
    msg.msg_speed    = fcr_pkg::join_pair(pl_r[4], pl_r[5]);
    msg.msg_angle    = fcr_pkg::join_pair(pl_r[6], pl_r[7]);
  end

  // Next frame state
  always_comb begin
    in_frame_nxt = in_frame_r;
    pos_nxt      = pos_r;
    if (!in_frame_r) begin
      if (rx_byte == start_code) begin
        in_frame_nxt = 1'b1;
      end
    end else if (emit) begin
      in_frame_nxt = 1'b0;
      pos_nxt      = '0;
    end else if (wr_en) begin
      pos_nxt = pos_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      pos_r      <= '0;
    end else if (step) begin
      in_frame_r <= in_frame_nxt;
      pos_r      <= pos_nxt;
    end
  end

  // Payload bytes: zero at reset and after each frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < fcr_pkg::MsgBytes; i++) pl_r[i] <= '0;
    end else if (step) begin
      if (emit) begin
        for (int i = 0; i < fcr_pkg::MsgBytes; i++) pl_r[i] <= '0;
      end else if (wr_en) begin
        pl_r[pos_r[fcr_pkg::SlotW-1:0]] <= rx_byte;
      end
    end
  end

endmodule

`default_nettype wire

// ----- tb/tb_framed_command_receiver.sv -----
// Testbench for framed_command_receiver: directed and random byte streams, with
// every message checked against a local frame predictor. Depends on fcr_pkg and framed_command_receiver.
`default_nettype none

module tb_framed_command_receiver;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned SETTLE_CYCLES = 4;

  // Tracks frame state and codes, holds the messages still owed by the block
  class command_tracker;
    logic [fcr_pkg::ByteW-1:0] start_code;
    logic [fcr_pkg::ByteW-1:0] stop_code;
    bit                        in_frame;
    int unsigned               fill;
    logic [fcr_pkg::ByteW-1:0] payload [fcr_pkg::MsgBytes];
    fcr_pkg::msg_t             expected_msgs [$];
    int                        errors;

    function new();
      start_code = fcr_pkg::START_RST;
      stop_code  = fcr_pkg::STOP_RST;
      in_frame   = 1'b0;
      fill       = 0;
      errors     = 0;
      foreach (payload[i]) payload[i] = '0;
    endfunction

    function void set_code(logic [fcr_pkg::CfgIdxW-1:0] idx, logic [fcr_pkg::ByteW-1:0] v);
      if (idx == fcr_pkg::CFG_START_CODE) start_code = v;
      else if (idx == fcr_pkg::CFG_STOP_CODE) stop_code = v;
    endfunction

    // hi lands on bits 14..7, lo is ORed in from bit 0
    function logic [fcr_pkg::FieldW-1:0] pair_value(logic [7:0] hi, logic [7:0] lo);
      logic [fcr_pkg::FieldW-1:0] hv;
      logic [fcr_pkg::FieldW-1:0] lv;
      hv = fcr_pkg::FieldW'(hi);
      lv = fcr_pkg::FieldW'(lo);
      return (hv << 7) | lv;
    endfunction

    // One accepted byte request
    function void note_byte(logic [fcr_pkg::ByteW-1:0] b);
      fcr_pkg::msg_t m;
      if (!in_frame) begin
        if (b == start_code) in_frame = 1'b1;
        return;
      end
      if (b != stop_code) begin
        if (fill < fcr_pkg::MsgBytes) begin
          payload[fill] = b;
          fill++;
        end
        return;
      end
      m.msg_type     = payload[0];
      m.msg_id       = payload[1];
      m.msg_distance = pair_value(payload[2], payload[3]);
      m.msg_speed    = pair_value(payload[4], payload[5]);
      m.msg_angle    = pair_value(payload[6], payload[7]);
      expected_msgs.push_back(m);
      in_frame = 1'b0;
      fill     = 0;
      foreach (payload[i]) payload[i] = '0;
    endfunction

    function void compare_field(string name, logic [14:0] want, logic [14:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    // One accepted message request
    function void check_msg(fcr_pkg::msg_t got);
      fcr_pkg::msg_t want;
      if (expected_msgs.size() == 0) begin
        $display("%0t: unexpected message: expected none, actual type %0h id %0h",
                 $time, got.msg_type, got.msg_id);
        errors++;
        return;
      end
      want = expected_msgs.pop_front();
      compare_field("msg_type", 15'(want.msg_type), 15'(got.msg_type));
      compare_field("msg_id", 15'(want.msg_id), 15'(got.msg_id));
      compare_field("msg_distance", want.msg_distance, got.msg_distance);
      compare_field("msg_speed", want.msg_speed, got.msg_speed);
      compare_field("msg_angle", want.msg_angle, got.msg_angle);
    endfunction

    function int pending();
      return expected_msgs.size();
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_we = 1'b0;
  logic [fcr_pkg::CfgIdxW-1:0]   cfg_index = '0;
  logic [fcr_pkg::ByteW-1:0]     cfg_wdata = '0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [fcr_pkg::ByteW-1:0]     in_rx_byte = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [fcr_pkg::ByteW-1:0]     out_msg_type;
  logic [fcr_pkg::ByteW-1:0]     out_msg_id;
  logic [fcr_pkg::FieldW-1:0]    out_msg_distance;
  logic [fcr_pkg::FieldW-1:0]    out_msg_speed;
  logic [fcr_pkg::FieldW-1:0]    out_msg_angle;

  command_tracker sb = new();
  bit             no_idle = 1'b0;
  int unsigned    phase_bytes = 0;
  int unsigned    cycles = 0;

  framed_command_receiver uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_msg_type     (out_msg_type),
    .out_msg_id       (out_msg_id),
    .out_msg_distance (out_msg_distance),
    .out_msg_speed    (out_msg_speed),
    .out_msg_angle    (out_msg_angle)
  );

  always #5 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Monitor: config writes, accepted bytes, accepted messages
  always @(posedge clk) begin
    fcr_pkg::msg_t got;
    if (rst_n) begin
      if (cfg_we) sb.set_code(cfg_index, cfg_wdata);
      if (in_valid && in_ready) sb.note_byte(in_rx_byte);
      if (out_valid && out_ready) begin
        got.msg_type     = out_msg_type;
        got.msg_id       = out_msg_id;
        got.msg_distance = out_msg_distance;
        got.msg_speed    = out_msg_speed;
        got.msg_angle    = out_msg_angle;
        sb.check_msg(got);
      end
    end
  end

  // Message sink with random stalls
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 4);
      repeat (stall) begin
        @(negedge clk);
        out_ready <= 1'b0;
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    phase_bytes++;
  endtask

  task automatic send_list(input logic [7:0] seq [$]);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  // Stop sending and let every owed message and in-flight byte clear
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [fcr_pkg::CfgIdxW-1:0] idx, input logic [7:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Payload byte biased toward the field extremes
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_frame(input int len, input bit closed);
    logic [7:0] d;
    send_byte(sb.start_code);
    for (int i = 0; i < len; i++) begin
      d = pick_byte();
      if (d == sb.stop_code) d = d ^ 8'h01;
      send_byte(d);
    end
    if (closed) send_byte(sb.stop_code);
  endtask

  task automatic run_phase(input logic [7:0] start_v, input logic [7:0] stop_v,
                           input int unsigned count, input bit quiet, input bit pause_mid);
    int  pick;
    int  r;
    int  len;
    bit  paused;
    paused = 1'b0;
    wait_idle();
    write_cfg(fcr_pkg::CFG_START_CODE, start_v);
    write_cfg(fcr_pkg::CFG_STOP_CODE, stop_v);
    no_idle     = quiet;
    phase_bytes = 0;
    while (phase_bytes < count) begin
      r   = $urandom_range(0, 19);
      len = (r < 14) ? 8 : (r < 17) ? $urandom_range(0, 7) : $urandom_range(9, 12);
      pick = $urandom_range(0, 9);
      if (pick < 7) send_frame(len, 1'b1);
      else if (pick == 7) send_frame(len, 1'b0);
      else repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
      // with pause_mid, the sender holds off once, at half the phase's bytes, until the sink has caught up
      if (pause_mid && !paused && phase_bytes >= count / 2) begin
        wait_idle();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed, reset codes: stray stop and noise while idle, extremes,
    // start code as data, empty and short frames, overlong frame
    send_list('{8'h03, 8'h55, 8'h02, 8'hFF, 8'h00, 8'h80, 8'h7F, 8'hFF, 8'h01,
                8'h02, 8'hAA, 8'h03});
    send_list('{8'h02, 8'h03, 8'h02, 8'h41, 8'h03});
    send_list('{8'h02, 8'h11, 8'h22, 8'hFE, 8'h01, 8'h80, 8'h7F, 8'h55, 8'hAA,
                8'hEE, 8'hDD, 8'h03});

    // Random phases across code settings, extremes and equal codes included
    run_phase(fcr_pkg::START_RST, fcr_pkg::STOP_RST, 140, 1'b1, 1'b0);
    run_phase(8'h00, 8'hFF, 140, 1'b0, 1'b1);
    run_phase(8'hFF, 8'h00, 140, 1'b0, 1'b0);
    run_phase(8'h7E, 8'h7E, 140, 1'b0, 1'b0);
    run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 140, 1'b0, 1'b0);
    run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 140, 1'b0, 1'b0);

    wait_idle();
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
